FILE: hw/rtl/lpvm_pkg.sv
// ----------------------------------------------------------------------------
// lpvm_pkg
// Shared types and constants for the leg position/velocity mode controller:
// field widths, register indexes and reset values, divider request/response.
// ----------------------------------------------------------------------------
package lpvm_pkg;

  localparam int LEG_W      = 3;
  localparam int ANGLE_W    = 16;
  localparam int VEL_W      = 16;
  localparam int CMD_W      = 17;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // stream packing
  localparam int S_DATA_W   = 56;  // leg, measured_angle, ref_angle, ref_velocity + pad
  localparam int S_USER_W   = 1;   // position_mode
  localparam int M_DATA_W   = 24;  // leg_out, command_value + pad
  localparam int M_USER_W   = 2;   // to_position_controller, switch_request

  localparam int LEG_COUNT_DEFAULT = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_WINDOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_CHANGE_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] POSITION_WINDOW_RST  = 16'd1274;
  localparam logic [CFG_W-1:0] RAMP_WINDOW_RST      = 16'd6372;
  localparam logic [CFG_W-1:0] REF_CHANGE_LIMIT_RST = 16'd36;

  // divider: 32-bit dividend whose quotient is known to fit 16 bits
  localparam int DIVIDEND_W = 32;
  localparam int QUOT_W     = 16;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [CFG_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hw/rtl/lpvm_div.sv
// ----------------------------------------------------------------------------
// lpvm_div
// Restoring shift-subtract divider, one quotient bit per cycle. The caller
// guarantees the upper half of the dividend is below the divisor, so the
// quotient fits 16 bits and 16 steps are enough.
// ----------------------------------------------------------------------------
module lpvm_div (
  input  logic               clk,
  input  logic               rst,
  input  lpvm_pkg::div_req_t req,
  output lpvm_pkg::div_rsp_t rsp
);
  import lpvm_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [CFG_W-1:0]  rem;
  logic [QUOT_W-1:0] work;
  logic [CFG_W-1:0]  divisor;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic              done;

  logic [CFG_W:0]    shifted;
  logic [CFG_W:0]    trial;
  logic              fits;

  always_comb begin
    shifted = {rem, work[QUOT_W-1]};
    trial   = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= req.dividend[DIVIDEND_W-1:QUOT_W];
        work    <= req.dividend[QUOT_W-1:0];
        divisor <= req.divisor;
        count   <= CNT_W'(QUOT_W);
        busy    <= 1'b1;
      end else if (busy) begin
        rem   <= fits ? trial[CFG_W-1:0] : shifted[CFG_W-1:0];
        work  <= {work[QUOT_W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule

FILE: hw/rtl/leg_position_velocity_mode_control_core.sv
// ----------------------------------------------------------------------------
// leg_position_velocity_mode_control_core
// Per-leg choice between position and velocity controller, with a ramped
// approach velocity computed by a shared iterative divider.
// ----------------------------------------------------------------------------
// Path: a beat is captured in ST_IDLE and evaluated in ST_EVAL; the ramp path
// then passes ST_MUL and ST_DIV (the divider) before ST_EMIT registers the
// output beat. Throughput: one tick at a time; the output register lets the
// next tick enter while a result waits.
// Reset (synchronous): all legs on the velocity controller, stored references
// zero, registers back to their defaults, output empty.
module leg_position_velocity_mode_control_core #(
  parameter int LEG_COUNT = lpvm_pkg::LEG_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // leg, measured_angle, ref_angle, ref_velocity (lowest bit up), zero pad
  input  logic [lpvm_pkg::S_DATA_W-1:0]   s_tdata,
  // position_mode
  input  logic [lpvm_pkg::S_USER_W-1:0]   s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // leg_out, command_value (lowest bit up), zero pad
  output logic [lpvm_pkg::M_DATA_W-1:0]   m_tdata,
  // to_position_controller, switch_request (lowest bit up)
  output logic [lpvm_pkg::M_USER_W-1:0]   m_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_write,
  input  logic [lpvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpvm_pkg::CFG_W-1:0]      cfg_data
);
  import lpvm_pkg::*;

  localparam int LEG_IDX_W = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
  localparam int LEG_CMP_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] position_window;
  logic [CFG_W-1:0] ramp_window;
  logic [CFG_W-1:0] ref_change_limit;

  // per-leg state
  logic                position_active [LEG_COUNT];
  logic [ANGLE_W-1:0]  last_reference  [LEG_COUNT];

  // captured tick
  logic [LEG_W-1:0]    leg_q;
  logic [ANGLE_W-1:0]  meas_q;
  logic [ANGLE_W-1:0]  ref_q;
  logic [VEL_W-1:0]    vel_q;
  logic                pmode_q;

  // ramp path operands
  logic [VEL_W-1:0]    vel_mag;
  logic [ANGLE_W-1:0]  dist_q;
  logic                vel_neg;

  // pending result
  logic [LEG_W-1:0]    res_leg;
  logic [CMD_W-1:0]    res_value;
  logic                res_pos;
  logic                res_sw;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // evaluation logic
  logic [LEG_IDX_W-1:0] leg_idx;
  logic                 leg_ok;
  logic                 pa;
  logic [ANGLE_W-1:0]   lr;
  logic [ANGLE_W:0]     diff_mr;
  logic [ANGLE_W-1:0]   abs_err;
  logic [ANGLE_W:0]     diff_lr;
  logic [ANGLE_W-1:0]   ref_move;
  logic                 near;
  logic                 moved;
  logic                 new_pa;
  logic                 sw;
  logic                 vel_pos;
  logic [ANGLE_W-1:0]   travel_err;
  logic                 need_div;
  logic [CMD_W-1:0]     value;
  logic [DIVIDEND_W-1:0] product;
  logic [CMD_W-1:0]     quot_ext;
  logic                 emit_go;

  assign leg_idx = LEG_IDX_W'(leg_q);
  assign leg_ok  = LEG_CMP_W'(leg_q) < LEG_CMP_W'(LEG_COUNT);

  always_comb begin
    pa       = position_active[leg_idx];
    lr       = last_reference[leg_idx];
    diff_mr  = {1'b0, meas_q} - {1'b0, ref_q};
    abs_err  = diff_mr[ANGLE_W] ? (~diff_mr[ANGLE_W-1:0] + 1'b1) : diff_mr[ANGLE_W-1:0];
    diff_lr  = {1'b0, lr} - {1'b0, ref_q};
    ref_move = diff_lr[ANGLE_W] ? (~diff_lr[ANGLE_W-1:0] + 1'b1) : diff_lr[ANGLE_W-1:0];
    near     = abs_err < position_window;
    moved    = ref_move > ref_change_limit;
    vel_pos  = !vel_q[VEL_W-1] && (vel_q != '0);
    // wrapped error in the direction of travel
    travel_err = vel_pos ? (~diff_mr[ANGLE_W-1:0] + 1'b1) : diff_mr[ANGLE_W-1:0];
    need_div = 1'b0;
    new_pa   = pa;
    sw       = 1'b0;
    value    = CMD_W'($signed(vel_q));
    if (pmode_q) begin
      if (near) begin
        new_pa = 1'b1;
        sw     = !pa;
        value  = {1'b0, ref_q};
      end else begin
        new_pa = pa && !moved;
        sw     = pa && moved;
        if (new_pa) begin
          value = {1'b0, ref_q};
        end else if (travel_err > ramp_window) begin
          value = CMD_W'($signed(vel_q));
        end else if (ramp_window == '0) begin
          value = '0;
        end else begin
          need_div = 1'b1;
        end
      end
    end
  end

  // single multiply ahead of the divider
  assign product  = DIVIDEND_W'(vel_mag) * DIVIDEND_W'(dist_q);
  assign quot_ext = {1'b0, div_rsp.quotient};

  always_comb begin
    div_req.start    = (state == ST_MUL);
    div_req.dividend = product;
    div_req.divisor  = ramp_window;
  end

  lpvm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready = (state == ST_IDLE);
  assign emit_go  = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      position_window  <= POSITION_WINDOW_RST;
      ramp_window      <= RAMP_WINDOW_RST;
      ref_change_limit <= REF_CHANGE_LIMIT_RST;
      for (int i = 0; i < LEG_COUNT; i++) begin
        position_active[i] <= 1'b0;
        last_reference[i]  <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_POSITION_WINDOW:  position_window  <= cfg_data;
          CFG_RAMP_WINDOW:      ramp_window      <= cfg_data;
          CFG_REF_CHANGE_LIMIT: ref_change_limit <= cfg_data;
          default: ;
        endcase
      end

      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            leg_q   <= s_tdata[LEG_W-1:0];
            meas_q  <= s_tdata[LEG_W +: ANGLE_W];
            ref_q   <= s_tdata[LEG_W+ANGLE_W +: ANGLE_W];
            vel_q   <= s_tdata[LEG_W+2*ANGLE_W +: VEL_W];
            pmode_q <= s_tuser[0];
            state   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!leg_ok) begin
            state <= ST_IDLE;
          end else begin
            if (pmode_q) begin
              position_active[leg_idx] <= new_pa;
              last_reference[leg_idx]  <= ref_q;
            end
            res_leg   <= leg_q;
            res_value <= value;
            res_pos   <= new_pa;
            res_sw    <= sw;
            vel_neg   <= vel_q[VEL_W-1];
            vel_mag   <= vel_q[VEL_W-1] ? (~vel_q + 1'b1) : vel_q;
            dist_q    <= travel_err;
            state     <= need_div ? ST_MUL : ST_EMIT;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            // truncation toward zero: divide magnitudes, then restore sign
            res_value <= vel_neg ? (~quot_ext + 1'b1) : quot_ext;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            m_tdata  <= {{(M_DATA_W-LEG_W-CMD_W){1'b0}}, res_value, res_leg};
            m_tuser  <= {res_sw, res_pos};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
